[sv/crsm_pkg.sv]
package crsm_pkg;

  localparam logic [2:0] CMD_RESTORE = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_SAVE    = 3'd2;
  localparam logic [2:0] CMD_DEL_ONE = 3'd3;
  localparam logic [2:0] CMD_DEL_ALL = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_LIST    = 3'd6;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_ENTRY  = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [2:0] {
    OP_RESTORE,
    OP_LOAD,
    OP_SAVE,
    OP_DEL_ONE,
    OP_DEL_ALL,
    OP_READ,
    OP_LIST,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_FINISH
  } bstate_t;

  typedef struct packed {
    op_t        op;
    logic       range_ok;
    logic [5:0] slot;
    logic [5:0] entry;
    logic [7:0] rindex;
    logic       rok;
    logic       both;
    logic [5:0] hnext;
    logic [6:0] hcount;
  } req_t;

endpackage

[sv/circular_record_slot_manager_top.sv]
// Requests wait in a two-entry queue; each result is registered and strobed on done.
// Throughput: one non-list request per cycle while no list is in progress; a list
// holds the back end while it scans the stored range, one slot of the valid map
// probed a cycle, and nothing is scanned when the ring is empty.
// Reset: next position, count and valid map cleared, base_sector set to 32;
// the record index store holds no reset value. The receiver cannot stall.
module circular_record_slot_manager_top #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [5:0]  slot,
  input  logic [5:0]  entry,
  input  logic [7:0]  record_index,
  input  logic        record_ok,
  input  logic        record_valid,
  input  logic        header_ok,
  input  logic [5:0]  header_next,
  input  logic [6:0]  header_count,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic [15:0] sector,
  output logic [7:0]  stored_index,
  output logic        valid_out,
  output logic [6:0]  count_out,
  output logic        last
);
  import crsm_pkg::*;

  req_t f_req;
  req_t q_req;
  logic f_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  crsm_front #(.SLOTS(SLOTS)) u_front (
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot         (slot),
    .entry        (entry),
    .record_index (record_index),
    .record_ok    (record_ok),
    .record_valid (record_valid),
    .header_ok    (header_ok),
    .header_next  (header_next),
    .header_count (header_count),
    .q_full       (q_full),
    .push         (f_push),
    .req          (f_req)
  );

  crsm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_req),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_req)
  );

  crsm_back #(.SLOTS(SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .pop          (q_pop),
    .done         (done),
    .status       (status),
    .slot_out     (slot_out),
    .sector       (sector),
    .stored_index (stored_index),
    .valid_out    (valid_out),
    .count_out    (count_out),
    .last         (last)
  );

endmodule

[sv/crsm_front.sv]
module crsm_front #(
  parameter int SLOTS = 64
) (
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    cmd,
  input  logic [5:0]    slot,
  input  logic [5:0]    entry,
  input  logic [7:0]    record_index,
  input  logic          record_ok,
  input  logic          record_valid,
  input  logic          header_ok,
  input  logic [5:0]    header_next,
  input  logic [6:0]    header_count,
  input  logic          q_full,
  output logic          push,
  output crsm_pkg::req_t req
);
  import crsm_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    req          = '0;
    req.slot     = slot;
    req.entry    = entry;
    req.rindex   = record_index;
    req.rok      = record_ok;
    req.both     = record_ok & record_valid;
    req.range_ok = 1'b1;
    case (cmd)
      CMD_RESTORE: req.op = OP_RESTORE;
      CMD_LOAD: begin
        req.op       = OP_LOAD;
        req.range_ok = {1'b0, slot} < 7'(SLOTS);
      end
      CMD_SAVE:    req.op = OP_SAVE;
      CMD_DEL_ONE: begin
        req.op       = OP_DEL_ONE;
        req.range_ok = {1'b0, entry} < 7'(SLOTS);
      end
      CMD_DEL_ALL: req.op = OP_DEL_ALL;
      CMD_READ:    req.op = OP_READ;
      CMD_LIST:    req.op = OP_LIST;
      default:     req.op = OP_REJECT;
    endcase
    // header normalization for restore
    if (header_ok && ({1'b0, header_next} < 7'(SLOTS))) begin
      req.hnext = header_next;
    end else begin
      req.hnext = '0;
    end
    if (!header_ok) begin
      req.hcount = '0;
    end else if (header_count < 7'(SLOTS)) begin
      req.hcount = header_count;
    end else begin
      req.hcount = 7'(SLOTS);
    end
  end

endmodule

[sv/crsm_queue.sv]
module crsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crsm_pkg::req_t din,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output crsm_pkg::req_t dout
);
  import crsm_pkg::*;

  req_t           store [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   cnt;

  assign full  = cnt == (QAW+1)'(QDEPTH);
  assign valid = cnt != '0;
  assign dout  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[sv/crsm_back.sv]
module crsm_back #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           q_valid,
  input  crsm_pkg::req_t q_req,
  output logic           pop,
  output logic           done,
  output logic [1:0]     status,
  output logic [5:0]     slot_out,
  output logic [15:0]    sector,
  output logic [7:0]     stored_index,
  output logic           valid_out,
  output logic [6:0]     count_out,
  output logic           last
);
  import crsm_pkg::*;

  localparam int AW = $clog2(SLOTS);

  bstate_t state, state_next;

  logic [15:0]    base_sector;
  logic [AW-1:0]  next_position, next_position_next;
  logic [6:0]     stored_count, stored_count_next;
  logic [SLOTS-1:0] valid_map;
  logic [7:0]     idx_mem [SLOTS];
  logic [7:0]     mem_rdata;

  logic [AW-1:0]  scan_i, scan_i_next;
  logic           scan_ph, scan_ph_next;
  logic           hit_d;
  logic [AW-1:0]  slot_d;
  logic           have_pend, have_pend_next;
  logic [AW-1:0]  pend_slot;
  logic [7:0]     pend_idx;
  logic [6:0]     list_n, list_n_next;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           vm_we;
  logic [AW-1:0]  vm_addr;
  logic           vm_val;
  logic           vm_clr;

  logic           res_valid;
  logic [1:0]     res_status;
  logic [5:0]     res_slot;
  logic [7:0]     res_idx;
  logic           res_vout;
  logic [6:0]     res_count;
  logic           res_last;
  logic           res_sec_zero;

  logic           list_start_scan;
  logic           scan_end;

  always_comb begin
    list_start_scan = (next_position != '0) || (stored_count != '0);
    scan_end = scan_ph ? (scan_i == next_position)
                       : ((scan_i == '0) && !(stored_count > 7'(next_position)));
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_req.op == OP_LIST) begin
          state_next = list_start_scan ? BK_SCAN : BK_FINISH;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN:  state_next = BK_FINISH;
      BK_FINISH: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop                = 1'b0;
    next_position_next = next_position;
    stored_count_next  = stored_count;
    scan_i_next        = scan_i;
    scan_ph_next       = scan_ph;
    have_pend_next     = have_pend;
    list_n_next        = list_n;
    mem_we             = 1'b0;
    mem_waddr          = q_req.slot[AW-1:0];
    mem_wdata          = q_req.rindex;
    vm_we              = 1'b0;
    vm_addr            = q_req.slot[AW-1:0];
    vm_val             = 1'b0;
    vm_clr             = 1'b0;
    res_valid          = 1'b0;
    res_status         = ST_DONE;
    res_slot           = '0;
    res_idx            = '0;
    res_vout           = 1'b0;
    res_count          = stored_count;
    res_last           = 1'b1;
    res_sec_zero       = 1'b0;

    // list entry found earlier is sent once the next one shows up
    if (hit_d && have_pend) begin
      res_valid   = 1'b1;
      res_status  = ST_ENTRY;
      res_slot    = 6'(pend_slot);
      res_idx     = pend_idx;
      res_count   = list_n + 7'd1;
      res_last    = 1'b0;
      list_n_next = list_n + 7'd1;
    end
    if (hit_d) begin
      have_pend_next = 1'b1;
    end

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          res_valid = 1'b1;
          case (q_req.op)
            OP_RESTORE: begin
              next_position_next = q_req.hnext[AW-1:0];
              stored_count_next  = q_req.hcount;
              res_slot           = q_req.hnext;
              res_count          = q_req.hcount;
            end
            OP_LOAD: begin
              if (!q_req.range_ok) begin
                res_status   = ST_REJECT;
                res_sec_zero = 1'b1;
              end else begin
                mem_we   = q_req.rok;
                vm_we    = 1'b1;
                vm_val   = q_req.both;
                res_slot = q_req.slot;
                res_idx  = q_req.rok ? q_req.rindex : 8'd0;
                res_vout = q_req.both;
              end
            end
            OP_SAVE: begin
              mem_we    = 1'b1;
              mem_waddr = next_position;
              mem_wdata = 8'(next_position);
              vm_we     = 1'b1;
              vm_addr   = next_position;
              vm_val    = 1'b1;
              if (stored_count < 7'(SLOTS)) begin
                stored_count_next = stored_count + 7'd1;
              end
              if (next_position == AW'(SLOTS - 1)) begin
                next_position_next = '0;
              end else begin
                next_position_next = next_position + 1'b1;
              end
              res_slot  = 6'(next_position);
              res_idx   = 8'(next_position);
              res_vout  = 1'b1;
              res_count = stored_count_next;
            end
            OP_DEL_ONE: begin
              if (!q_req.range_ok || ({1'b0, q_req.slot} >= stored_count)) begin
                res_status   = ST_REJECT;
                res_sec_zero = 1'b1;
              end else begin
                mem_we    = q_req.rok;
                mem_waddr = q_req.entry[AW-1:0];
                vm_we     = 1'b1;
                vm_addr   = q_req.entry[AW-1:0];
                vm_val    = 1'b0;
                res_slot  = q_req.slot;
              end
            end
            OP_DEL_ALL: begin
              next_position_next = '0;
              stored_count_next  = '0;
              vm_clr             = 1'b1;
              res_count          = '0;
            end
            OP_READ: begin
              if ({1'b0, q_req.slot} >= stored_count) begin
                res_status   = ST_REJECT;
                res_sec_zero = 1'b1;
              end else begin
                res_slot = q_req.slot;
                res_vout = q_req.both;
              end
            end
            OP_LIST: begin
              res_valid      = 1'b0;
              have_pend_next = 1'b0;
              list_n_next    = '0;
              if (next_position != '0) begin
                scan_ph_next = 1'b0;
                scan_i_next  = next_position - 1'b1;
              end else begin
                scan_ph_next = 1'b1;
                scan_i_next  = AW'(stored_count - 7'd1);
              end
            end
            default: begin
              res_status   = ST_REJECT;
              res_sec_zero = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (!scan_ph && scan_i == '0) begin
          if (stored_count > 7'(next_position)) begin
            scan_ph_next = 1'b1;
            scan_i_next  = AW'(stored_count - 7'd1);
          end
        end else if (!scan_end) begin
          scan_i_next = scan_i - 1'b1;
        end
      end
      BK_FINISH: begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        if (have_pend) begin
          res_status = ST_ENTRY;
          res_slot   = 6'(pend_slot);
          res_idx    = pend_idx;
          res_count  = list_n + 7'd1;
        end else begin
          res_status   = ST_EMPTY;
          res_count    = '0;
          res_sec_zero = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      idx_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= idx_mem[scan_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      base_sector   <= 16'd32;
      next_position <= '0;
      stored_count  <= '0;
      valid_map     <= '0;
      scan_i        <= '0;
      scan_ph       <= 1'b0;
      hit_d         <= 1'b0;
      have_pend     <= 1'b0;
      list_n        <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      if (cfg_wr_en) begin
        base_sector <= cfg_wr_data;
      end
      next_position <= next_position_next;
      stored_count  <= stored_count_next;
      if (vm_clr) begin
        valid_map <= '0;
      end else if (vm_we) begin
        valid_map[vm_addr] <= vm_val;
      end
      scan_i    <= scan_i_next;
      scan_ph   <= scan_ph_next;
      hit_d     <= (state == BK_SCAN) && valid_map[scan_i];
      have_pend <= have_pend_next;
      list_n    <= list_n_next;
      done      <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    slot_d <= scan_i;
    if (hit_d) begin
      pend_slot <= slot_d;
      pend_idx  <= mem_rdata;
    end
    status       <= res_status;
    slot_out     <= res_slot;
    sector       <= res_sec_zero ? 16'd0 : base_sector + 16'(res_slot);
    stored_index <= res_idx;
    valid_out    <= res_vout;
    count_out    <= res_count;
    last         <= res_last;
  end

endmodule
